// ===== hdl/lsp_pkg.sv =====
// shared types and constants of the led sequence player
// no dependencies
`default_nettype none

package lsp_pkg;

    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int KIND_W   = 3;
    localparam int LEVEL_W  = 8;
    localparam int ARG_W    = 16;
    localparam int COLOUR_W = 3 * LEVEL_W;

    // remainder unit: reciprocal multiply for the quotient, multiply-back and subtract
    localparam int RECIP_W = 32;
    localparam int PROD_W  = ARG_W + RECIP_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET    = 3'd0,
        KIND_WAIT   = 3'd1,
        KIND_GOTO   = 3'd2,
        KIND_END    = 3'd3,
        KIND_REPEAT = 3'd4
    } chunk_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [COLOUR_W-1:0] colour;
        logic [ARG_W-1:0]    arg;
    } chunk_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_EXEC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/lsp_if.sv =====
// valid/ready channel interfaces of the led sequence player
// depends on lsp_pkg
`default_nettype none

interface lsp_req_if;
    import lsp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [INDEX_W-1:0]   chunk_index;
    logic [KIND_W-1:0]    chunk_kind;
    logic [LEVEL_W-1:0]   chunk_red;
    logic [LEVEL_W-1:0]   chunk_green;
    logic [LEVEL_W-1:0]   chunk_blue;
    logic [ARG_W-1:0]     chunk_arg;

    modport source (
        output valid, req_type, chunk_index, chunk_kind,
               chunk_red, chunk_green, chunk_blue, chunk_arg,
        input  ready
    );
    modport sink (
        input  valid, req_type, chunk_index, chunk_kind,
               chunk_red, chunk_green, chunk_blue, chunk_arg,
        output ready
    );
endinterface

interface lsp_res_if;
    import lsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] led_red;
    logic [LEVEL_W-1:0] led_green;
    logic [LEVEL_W-1:0] led_blue;
    logic               led_lit;
    logic               playing;

    modport source (
        output valid, led_red, led_green, led_blue, led_lit, playing,
        input  ready
    );
    modport sink (
        input  valid, led_red, led_green, led_blue, led_lit, playing,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/led_sequence_player.sv =====
// led sequence player top level: chunk store, sequencer and shared remainder unit
// depends on lsp_pkg and the channel interfaces in lsp_if
`default_nettype none

// usage
//   req channel: one beat per request. load writes a chunk word (set colour,
//   wait, goto, end, repeat) into the store, start rewinds to chunk 0 and sets
//   the sequence playing, tick stands for one millisecond of play.
//   res channel: exactly one beat per request, carrying the led colour and the
//   playing flag as they stand after that request.
// timing
//   one request is in flight at a time; req.ready is high only while idle.
//   start, unknown requests, ticks while stopped and ticks that only count down a
//   wait go straight to the result. load wraps the slot in the reciprocal
//   remainder unit, then writes it. a tick that plays chunks does a store read,
//   then execute, per chunk, up to MAX_STEPS chunks, with one more read when
//   the step limit stops it, and a goto wraps its target in the remainder unit.
// reset
//   pointer, wait, repeat counter and colour clear and the player is stopped;
//   the led outputs are not reset. the chunk store is not cleared; play only loaded slots.
// backpressure
//   the result sits in an output register; while res.ready is low a finished
//   result holds and the next request is not accepted once the sequencer has
//   another result waiting behind it.

module led_sequence_player #(
    parameter int STORE_DEPTH = 64,
    parameter int MAX_STEPS   = 64
) (
    input  wire        clk,
    input  wire        rst_n,
    lsp_req_if.sink    req,
    lsp_res_if.source  res
);
    import lsp_pkg::*;

    localparam int PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SW = $clog2(MAX_STEPS + 1);

    // ceil(2^RECIP_W / STORE_DEPTH), exact quotient for every arg value
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_W) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));

    // chunk store, read data registered
    chunk_t store_mem [STORE_DEPTH];
    chunk_t rd_data_reg;

    logic           store_we;
    logic [PW-1:0]  store_addr;
    chunk_t         store_wdata;

    // sequencer state
    state_t state_reg, state_next;

    // play state
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic                armed_reg, armed_next;
    logic [ARG_W-1:0]    repeats_reg, repeats_next;
    logic [ARG_W-1:0]    wait_reg, wait_next;
    logic                running_reg, running_next;
    logic [COLOUR_W-1:0] colour_reg, colour_next;
    logic [SW-1:0]       steps_reg, steps_next;

    // latched load word
    chunk_t              word_reg, word_next;

    // remainder unit
    logic [ARG_W-1:0]     rem_reg, rem_next;
    logic [ARG_W-1:0]     quot_reg, quot_next;
    logic                 mod_phase_reg, mod_phase_next;
    logic                 mod_goto_reg, mod_goto_next;
    logic [PROD_W-1:0]    mod_prod;
    logic [ARG_W-1:0]     quot_times_depth;
    logic [ARG_W-1:0]     rem_fold;
    logic                 mod_last;

    // output register
    logic                res_valid_reg, res_valid_next;
    logic [COLOUR_W-1:0] res_colour_reg, res_colour_next;
    logic                res_playing_reg, res_playing_next;

    logic                req_fire;
    logic                out_free;
    logic [PW-1:0]       ptr_inc;
    logic [ARG_W-1:0]    wait_dec;
    logic [ARG_W-1:0]    rep_eff;
    logic                steps_done;

    assign req_fire   = req.valid && req.ready;
    assign out_free   = !res_valid_reg || res.ready;
    assign ptr_inc    = (ptr_reg == PW'(STORE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign wait_dec   = (wait_reg != '0) ? wait_reg - 1'b1 : '0;
    assign rep_eff    = armed_reg ? repeats_reg : rd_data_reg.arg;
    assign steps_done = (steps_reg == SW'(MAX_STEPS));

    // phase 0: quotient by reciprocal multiply; phase 1: multiply back, subtract
    assign mod_prod         = PROD_W'(rem_reg) * PROD_W'(RECIP);
    assign quot_times_depth = quot_reg * ARG_W'(STORE_DEPTH);
    assign rem_fold         = rem_reg - quot_times_depth;
    assign mod_last         = mod_phase_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_LOAD)
                        state_next = ST_MOD;
                    else if (req.req_type == REQ_TICK && running_reg && wait_dec == '0)
                        state_next = ST_RUN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_MOD:
            begin
                if (mod_last)
                    state_next = ST_DONE;
            end
            ST_RUN:
            begin
                state_next = steps_done ? ST_DONE : ST_EXEC;
            end
            ST_EXEC:
            begin
                case (rd_data_reg.kind)
                    KIND_WAIT:   state_next = (rd_data_reg.arg != '0) ? ST_DONE : ST_RUN;
                    KIND_GOTO:   state_next = ST_MOD;
                    KIND_END:    state_next = ST_DONE;
                    default:     state_next = ST_RUN;
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ptr_next         = ptr_reg;
        armed_next       = armed_reg;
        repeats_next     = repeats_reg;
        wait_next        = wait_reg;
        running_next     = running_reg;
        colour_next      = colour_reg;
        steps_next       = steps_reg;
        word_next        = word_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        mod_phase_next   = mod_phase_reg;
        mod_goto_next    = mod_goto_reg;
        res_valid_next   = res_valid_reg;
        res_colour_next  = res_colour_reg;
        res_playing_next = res_playing_reg;
        store_we         = 1'b0;
        store_addr       = rem_fold[PW-1:0];
        store_wdata      = word_reg;

        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    steps_next = '0;
                    unique case (req.req_type)
                        REQ_LOAD:
                        begin
                            word_next.kind   = req.chunk_kind;
                            word_next.colour = {req.chunk_red, req.chunk_green, req.chunk_blue};
                            word_next.arg    = req.chunk_arg;
                            rem_next         = ARG_W'(req.chunk_index);
                            mod_phase_next   = 1'b0;
                            mod_goto_next    = 1'b0;
                        end
                        REQ_START:
                        begin
                            ptr_next     = '0;
                            armed_next   = 1'b0;
                            repeats_next = '0;
                            wait_next    = '0;
                            running_next = 1'b1;
                        end
                        REQ_TICK:
                        begin
                            if (running_reg)
                                wait_next = wait_dec;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                mod_phase_next = 1'b1;
                if (!mod_last)
                begin
                    quot_next = mod_prod[PROD_W-1:RECIP_W];
                end
                else
                begin
                    if (mod_goto_reg)
                    begin
                        ptr_next  = rem_fold[PW-1:0];
                        wait_next = ARG_W'(1);
                    end
                    else
                    begin
                        store_we = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
            end
            ST_EXEC:
            begin
                steps_next = steps_reg + 1'b1;
                case (rd_data_reg.kind)
                    KIND_SET:
                    begin
                        colour_next = rd_data_reg.colour;
                        ptr_next    = ptr_inc;
                    end
                    KIND_WAIT:
                    begin
                        ptr_next = ptr_inc;
                        if (rd_data_reg.arg != '0)
                            wait_next = rd_data_reg.arg;
                    end
                    KIND_GOTO:
                    begin
                        rem_next       = rd_data_reg.arg;
                        mod_phase_next = 1'b0;
                        mod_goto_next  = 1'b1;
                    end
                    KIND_END:
                    begin
                        running_next = 1'b0;
                    end
                    KIND_REPEAT:
                    begin
                        if (rep_eff == '0)
                        begin
                            armed_next = 1'b0;
                            ptr_next   = ptr_inc;
                        end
                        else
                        begin
                            armed_next   = 1'b1;
                            repeats_next = rep_eff - 1'b1;
                            ptr_next     = '0;
                        end
                    end
                    default:
                    begin
                        // unknown kinds are skipped
                        ptr_next = ptr_inc;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_colour_next  = colour_reg;
                    res_playing_next = running_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // chunk store: one write port, one registered read at the play pointer
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_addr] <= store_wdata;
        rd_data_reg <= store_mem[ptr_reg];
    end

    // control and play state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            armed_reg     <= 1'b0;
            repeats_reg   <= '0;
            wait_reg      <= '0;
            running_reg   <= 1'b0;
            colour_reg    <= '0;
            steps_reg     <= '0;
            mod_phase_reg <= 1'b0;
            mod_goto_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            armed_reg     <= armed_next;
            repeats_reg   <= repeats_next;
            wait_reg      <= wait_next;
            running_reg   <= running_next;
            colour_reg    <= colour_next;
            steps_reg     <= steps_next;
            mod_phase_reg <= mod_phase_next;
            mod_goto_reg  <= mod_goto_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg        <= word_next;
        rem_reg         <= rem_next;
        quot_reg        <= quot_next;
        res_colour_reg  <= res_colour_next;
        res_playing_reg <= res_playing_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.led_red   = res_colour_reg[3*LEVEL_W-1:2*LEVEL_W];
    assign res.led_green = res_colour_reg[2*LEVEL_W-1:LEVEL_W];
    assign res.led_blue  = res_colour_reg[LEVEL_W-1:0];
    assign res.led_lit   = (res_colour_reg != '0);
    assign res.playing   = res_playing_reg;

endmodule

`default_nettype wire

// ===== bench/tb_led_sequence_player.sv =====
// testbench of the led sequence player: directed chunk programs, then random ones
// depends on lsp_pkg, the channel interfaces in lsp_if and led_sequence_player

module tb_led_sequence_player;
    timeunit 1ns;
    timeprecision 1ps;

    import lsp_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int MAX_STEPS    = 64;
    localparam int RANDOM_ITEMS = 420;

    // chunk kinds the player does not know, skipped like a no-op
    localparam logic [KIND_W-1:0] SPARE_KIND_LO  = 3'd5;
    localparam logic [KIND_W-1:0] SPARE_KIND_MID = 3'd6;
    localparam logic [KIND_W-1:0] SPARE_KIND_HI  = 3'd7;

    // one request beat as the bench builds it
    typedef struct {
        req_type_t            req;
        logic [INDEX_W-1:0]   index;
        logic [KIND_W-1:0]    kind;
        logic [LEVEL_W-1:0]   red;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   blue;
        logic [ARG_W-1:0]     arg;
    } request_t;

    // led state carried by one result beat
    typedef struct {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic               lit;
        logic               playing;
    } led_state_t;

    logic clk;
    logic rst_n;

    lsp_req_if req_ch ();
    lsp_res_if res_ch ();

    led_sequence_player #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_STEPS   (MAX_STEPS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // player state as the bench sees it
    chunk_t              store_copy [STORE_DEPTH];
    logic [INDEX_W-1:0]  play_ptr;
    logic                repeat_armed;
    logic [ARG_W-1:0]    repeats_left;
    logic [ARG_W-1:0]    wait_left;
    logic                running;
    logic [COLOUR_W-1:0] colour_now;

    // led states still owed by the block, oldest first
    led_state_t pending_led_states [$];

    int  mismatch_count = 0;
    int  requests_sent  = 0;
    // both sides stop idling while this is set
    bit  quiet_run      = 1'b0;
    // request valid is being held high by the sender
    bit  req_held       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // walk chunks from the play pointer until a wait, goto, end or the step limit
    function automatic void play_chunks();
        chunk_t cw;
        for (int n = 0; n < MAX_STEPS; n++)
        begin
            cw = store_copy[play_ptr];
            case (cw.kind)
                KIND_SET:
                begin
                    colour_now = cw.colour;
                    play_ptr   = INDEX_W'((play_ptr + 1) % STORE_DEPTH);
                end
                KIND_WAIT:
                begin
                    play_ptr = INDEX_W'((play_ptr + 1) % STORE_DEPTH);
                    // a zero wait costs no time
                    if (cw.arg != '0)
                    begin
                        wait_left = cw.arg;
                        return;
                    end
                end
                KIND_GOTO:
                begin
                    // target wraps, work resumes on the next tick
                    play_ptr  = INDEX_W'(cw.arg % STORE_DEPTH);
                    wait_left = ARG_W'(1);
                    return;
                end
                KIND_END:
                begin
                    // colour stays as it is
                    running = 1'b0;
                    return;
                end
                KIND_REPEAT:
                begin
                    // count is loaded on the first visit only
                    if (!repeat_armed)
                    begin
                        repeats_left = cw.arg;
                        repeat_armed = 1'b1;
                    end
                    if (repeats_left == '0)
                    begin
                        repeat_armed = 1'b0;
                        play_ptr     = INDEX_W'((play_ptr + 1) % STORE_DEPTH);
                    end
                    else
                    begin
                        repeats_left--;
                        play_ptr = '0;
                    end
                end
                default:
                    play_ptr = INDEX_W'((play_ptr + 1) % STORE_DEPTH);
            endcase
        end
    endfunction

    // apply one accepted request and return the led state it leaves
    function automatic led_state_t step_player(request_t r);
        led_state_t s;
        logic [INDEX_W-1:0] slot;
        case (r.req)
            REQ_LOAD:
            begin
                slot = INDEX_W'(r.index % STORE_DEPTH);
                store_copy[slot].kind   = r.kind;
                store_copy[slot].colour = {r.red, r.green, r.blue};
                store_copy[slot].arg    = r.arg;
            end
            REQ_START:
            begin
                // rewind, disarm, drop any pending wait; no chunk runs yet
                play_ptr     = '0;
                repeat_armed = 1'b0;
                repeats_left = '0;
                wait_left    = '0;
                running      = 1'b1;
            end
            REQ_TICK:
            begin
                // ticks while stopped do nothing
                if (running)
                begin
                    if (wait_left != '0)
                        wait_left--;
                    if (wait_left == '0)
                        play_chunks();
                end
            end
            default:
                ;
        endcase
        {s.red, s.green, s.blue} = colour_now;
        s.lit     = (colour_now != '0);
        s.playing = running;
        return s;
    endfunction

    // one request beat: random gap, then hold valid until the block takes it
    task automatic send_request(input request_t r);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            if (req_held)
            begin
                req_ch.valid <= 1'b0;
                req_held = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req;
        req_ch.chunk_index <= r.index;
        req_ch.chunk_kind  <= r.kind;
        req_ch.chunk_red   <= r.red;
        req_ch.chunk_green <= r.green;
        req_ch.chunk_blue  <= r.blue;
        req_ch.chunk_arg   <= r.arg;
        req_held = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // accepted at this edge
        pending_led_states.push_back(step_player(r));
        requests_sent++;
    endtask

    task automatic load_chunk(input int slot, input logic [KIND_W-1:0] kind,
                              input logic [COLOUR_W-1:0] rgb, input logic [ARG_W-1:0] arg);
        request_t r;
        r.req   = REQ_LOAD;
        r.index = slot[INDEX_W-1:0];
        r.kind  = kind;
        {r.red, r.green, r.blue} = rgb;
        r.arg   = arg;
        send_request(r);
    endtask

    // start, tick or unknown request; payload is noise the block must ignore
    task automatic send_control(input req_type_t rq);
        request_t r;
        r.req   = rq;
        r.index = INDEX_W'($urandom);
        r.kind  = KIND_W'($urandom);
        r.red   = LEVEL_W'($urandom);
        r.green = LEVEL_W'($urandom);
        r.blue  = LEVEL_W'($urandom);
        r.arg   = ARG_W'($urandom);
        send_request(r);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_control(REQ_TICK);
    endtask

    // drop valid and hold off until every owed result beat has come back
    task automatic drain_results();
        if (req_held)
        begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
        while (pending_led_states.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // the store is not cleared by reset, so every slot gets a word before any play
    task automatic test_fill_store();
        for (int i = 0; i < STORE_DEPTH - 1; i++)
            load_chunk(i, KIND_SET, COLOUR_W'($urandom), ARG_W'($urandom));
        load_chunk(STORE_DEPTH - 1, KIND_END, '0, '0);
    endtask

    // ticks before start, unknown request, start that runs no chunk
    task automatic test_idle_requests();
        send_ticks(2);
        send_control(REQ_NONE);
        send_control(REQ_START);
        send_control(REQ_NONE);
    endtask

    // full white, a wait of two ticks, black (led off), end, tick after end
    task automatic test_colour_and_end();
        load_chunk(0, KIND_SET, '1, '0);
        load_chunk(1, KIND_WAIT, '0, 16'd2);
        load_chunk(2, KIND_SET, '0, '0);
        load_chunk(3, KIND_END, '1, '1);
        send_control(REQ_START);
        send_ticks(4);
    endtask

    // spare kinds are skipped, goto target and pointer both wrap, load while playing
    task automatic test_goto_and_spare_kinds();
        load_chunk(0, KIND_SET, 24'h123456, '0);
        load_chunk(1, SPARE_KIND_LO, '1, '1);
        load_chunk(2, SPARE_KIND_HI, '1, '1);
        load_chunk(3, KIND_GOTO, '0, '1);
        load_chunk(STORE_DEPTH - 1, SPARE_KIND_MID, '0, '0);
        send_control(REQ_START);
        send_ticks(2);
        load_chunk(2, KIND_SET, 24'hABCDEF, '0);
        send_ticks(2);
    endtask

    // zero wait, longest wait, restart drops the pending wait
    task automatic test_long_wait_and_restart();
        load_chunk(0, KIND_SET, 24'h00FF00, '0);
        load_chunk(1, KIND_WAIT, '0, '0);
        load_chunk(2, KIND_WAIT, '0, '1);
        load_chunk(3, KIND_END, '0, '0);
        send_control(REQ_START);
        send_ticks(3);
        send_control(REQ_START);
        send_ticks(2);
    endtask

    // repeat twice back to chunk 0, then a repeat of zero falls straight through
    task automatic test_repeat();
        load_chunk(0, KIND_SET, 24'hFF0000, '0);
        load_chunk(1, KIND_WAIT, '0, 16'd1);
        load_chunk(2, KIND_SET, 24'h0000FF, '0);
        load_chunk(3, KIND_REPEAT, '0, 16'd2);
        load_chunk(4, KIND_REPEAT, '0, '0);
        load_chunk(5, KIND_END, '0, '0);
        send_control(REQ_START);
        send_ticks(5);
    endtask

    // a huge repeat loop with no wait: every tick stops at the step limit
    task automatic test_step_limit();
        load_chunk(0, KIND_SET, 24'h010203, '0);
        load_chunk(1, KIND_SET, 24'hFEFDFC, '0);
        load_chunk(2, KIND_REPEAT, '0, '1);
        send_control(REQ_START);
        send_ticks(4);
    endtask

    // one well-formed chunk for a program of len slots
    task automatic load_random_chunk(input int slot, input int len);
        logic [COLOUR_W-1:0] rgb;
        rgb = ($urandom_range(0, 7) == 0) ? '0 : COLOUR_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: load_chunk(slot, KIND_SET, rgb, ARG_W'($urandom));
            4, 5, 6:    load_chunk(slot, KIND_WAIT, rgb, ARG_W'($urandom_range(0, 4)));
            7:          load_chunk(slot, KIND_REPEAT, rgb, ARG_W'($urandom_range(0, 3)));
            // upper bits of the target are dropped by the wrap
            8:          load_chunk(slot, KIND_GOTO, rgb,
                                   ARG_W'($urandom_range(0, len)
                                          + STORE_DEPTH * $urandom_range(0, 1023)));
            default:    load_chunk(slot, KIND_W'($urandom_range(SPARE_KIND_LO, SPARE_KIND_HI)),
                                   rgb, ARG_W'($urandom));
        endcase
    endtask

    // short random programs played by ticks, with stray loads, starts and unknown requests
    task automatic test_random_programs();
        int stop_at;
        int len;
        int pick;
        stop_at = requests_sent + RANDOM_ITEMS;
        while (requests_sent < stop_at)
        begin
            quiet_run = ($urandom_range(0, 4) == 0);
            len = $urandom_range(2, 12);
            for (int i = 0; i < len; i++)
                load_random_chunk(i, len);
            if ($urandom_range(0, 1) == 0)
                load_chunk(len, KIND_END, COLOUR_W'($urandom), ARG_W'($urandom));
            else
                load_chunk(len, KIND_GOTO, COLOUR_W'($urandom), '0);
            send_control(REQ_START);
            repeat ($urandom_range(8, 30))
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_control(REQ_NONE);
                else if (pick == 1)
                    send_control(REQ_START);
                else if (pick == 2)
                    load_chunk($urandom_range(0, STORE_DEPTH - 1),
                               KIND_W'($urandom_range(0, 7)),
                               COLOUR_W'($urandom),
                               ARG_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(0, 4)));
                else
                    send_control(REQ_TICK);
            end
            // now and then let the block run dry before the next program
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end
        quiet_run = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [LEVEL_W-1:0] want,
                                        input logic [LEVEL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stall before each beat, then compare with the oldest owed state
    initial
    begin : result_checker
        led_state_t want;
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_run ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            if (pending_led_states.size() == 0)
            begin
                $error("result beat with no request behind it");
                mismatch_count++;
            end
            else
            begin
                want = pending_led_states.pop_front();
                check_field("led_red", want.red, res_ch.led_red);
                check_field("led_green", want.green, res_ch.led_green);
                check_field("led_blue", want.blue, res_ch.led_blue);
                check_field("led_lit", LEVEL_W'(want.lit), LEVEL_W'(res_ch.led_lit));
                check_field("playing", LEVEL_W'(want.playing), LEVEL_W'(res_ch.playing));
            end
        end
    end

    initial
    begin
        // every block input known from time zero
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_NONE;
        req_ch.chunk_index <= '0;
        req_ch.chunk_kind  <= '0;
        req_ch.chunk_red   <= '0;
        req_ch.chunk_green <= '0;
        req_ch.chunk_blue  <= '0;
        req_ch.chunk_arg   <= '0;
        play_ptr     = '0;
        repeat_armed = 1'b0;
        repeats_left = '0;
        wait_left    = '0;
        running      = 1'b0;
        colour_now   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_store();
        test_idle_requests();
        test_colour_and_end();
        test_goto_and_spare_kinds();
        drain_results();
        test_long_wait_and_restart();
        test_repeat();
        test_step_limit();
        test_random_programs();

        // everything owed must come back, then a margin for a stray beat
        drain_results();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== led_sequence_player.f =====
hdl/lsp_pkg.sv
hdl/lsp_if.sv
hdl/led_sequence_player.sv
bench/tb_led_sequence_player.sv
